@@ rtl/core/obl_pkg.sv @@
// ----------------------------------------------------------------------------
// obl_pkg
// Shared types, widths and the octant table of the line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obl_pkg;

  localparam int COORD_BITS = 6;
  // decision term spans about +/- 2 * (2^COORD_BITS - 1)
  localparam int DEC_BITS = COORD_BITS + 3;
  localparam int CNT_BITS = COORD_BITS;

  localparam int IN_BITS     = 4 * COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * COORD_BITS + 1 + 4;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]          len_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic [3:0]                   region_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic load;  // capture a segment and set up the loop
    logic step;  // emit one item into the output register
  } obl_cmd_t;

  typedef struct packed {
    logic last;  // the next step emits the final item of the segment
  } obl_sts_t;

  localparam region_t REGION_NONE = 4'd0;

  // octant label indexed by {swap, mirror x, mirror y}
  function automatic region_t region_lookup(input logic swap, input logic fx,
                                            input logic fy);
    region_t r;
    case ({swap, fx, fy})
      3'b000:  r = 4'd1;
      3'b001:  r = 4'd8;
      3'b010:  r = 4'd4;
      3'b011:  r = 4'd5;
      3'b100:  r = 4'd2;
      3'b101:  r = 4'd3;
      3'b110:  r = 4'd7;
      3'b111:  r = 4'd6;
      default: r = REGION_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/obl_ctrl.sv @@
// ----------------------------------------------------------------------------
// obl_ctrl
// Sequencer: accepts a segment, then paces one step per free output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obl_ctrl
  import obl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output obl_cmd_t      cmd,
  input  wire obl_sts_t sts
);

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  logic   slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = slot_free;
        if (slot_free && sts.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.step) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

`ifndef SYNTHESIS
  a_load_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.step))
    else $error("load and step in the same cycle");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.step && sts.last |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after the last item");

  a_valid_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.step))
    else $error("output item appeared without a step");
`endif

endmodule

`default_nettype wire

@@ rtl/core/obl_datapath.sv @@
// ----------------------------------------------------------------------------
// obl_datapath
// Octant setup and the midpoint Bresenham step unit with its output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obl_datapath
  import obl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  input  wire obl_cmd_t              cmd,
  output obl_sts_t                   sts,
  output coord_t                     pixel_x,
  output coord_t                     pixel_y,
  output logic                       step_diagonal,
  output region_t                    region_code,
  output logic                       pixel_valid,
  output logic                       last_pixel
);

  localparam int W = COORD_BITS;

  // setup, straight from the input item
  coord_t                sx, sy, ex, ey;
  logic signed [W:0]     dx, dy, adx_s, ady_s;
  len_t                  adx, ady, maj_in, min_in;
  logic                  swap_in, fx_in, fy_in, zero_in;
  dec_t                  two_min, two_maj;

  // loop state
  coord_t  cur_x, cur_y;
  len_t    major_len, cnt;
  dec_t    dec, inc_e, inc_ne;
  logic    swap, fx, fy, zero;
  region_t region;

  // one step
  logic   diag;
  coord_t maj_step, min_step, nx, ny;

  assign sx = s_tdata[W-1:0];
  assign sy = s_tdata[2*W-1:W];
  assign ex = s_tdata[3*W-1:2*W];
  assign ey = s_tdata[4*W-1:3*W];

  assign dx      = {ex[W-1], ex} - {sx[W-1], sx};
  assign dy      = {ey[W-1], ey} - {sy[W-1], sy};
  assign adx_s   = dx[W] ? -dx : dx;
  assign ady_s   = dy[W] ? -dy : dy;
  assign adx     = adx_s[W-1:0];
  assign ady     = ady_s[W-1:0];
  assign swap_in = ady > adx;
  assign fx_in   = swap_in ? dy[W] : dx[W];
  assign fy_in   = swap_in ? dx[W] : dy[W];
  assign maj_in  = swap_in ? ady : adx;
  assign min_in  = swap_in ? adx : ady;
  assign zero_in = (dx == '0) && (dy == '0);
  assign two_min = {2'b00, min_in, 1'b0};
  assign two_maj = {2'b00, maj_in, 1'b0};

  // a tie (decision zero) takes the diagonal step
  assign diag     = !dec[DEC_BITS-1];
  assign maj_step = fx ? {W{1'b1}} : coord_t'(1);
  assign min_step = fy ? {W{1'b1}} : coord_t'(1);

  always_comb begin
    nx = cur_x;
    ny = cur_y;
    if (swap) begin
      ny = cur_y + maj_step;
      if (diag) nx = cur_x + min_step;
    end else begin
      nx = cur_x + maj_step;
      if (diag) ny = cur_y + min_step;
    end
  end

  assign sts.last = zero || (cnt == major_len);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x     <= sx;
      cur_y     <= sy;
      major_len <= maj_in;
      cnt       <= len_t'(1);
      dec       <= two_min - {3'b000, maj_in};
      inc_e     <= two_min;
      inc_ne    <= two_min - two_maj;
      swap      <= swap_in;
      fx        <= fx_in;
      fy        <= fy_in;
      zero      <= zero_in;
      region    <= region_lookup(swap_in, fx_in, fy_in);
    end else if (cmd.step) begin
      cur_x <= nx;
      cur_y <= ny;
      cnt   <= cnt + len_t'(1);
      dec   <= dec + (diag ? inc_ne : inc_e);
    end
  end

  // output register; zero-length segment gives one empty item
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      last_pixel <= sts.last;
      if (zero) begin
        pixel_x       <= '0;
        pixel_y       <= '0;
        step_diagonal <= 1'b0;
        region_code   <= REGION_NONE;
        pixel_valid   <= 1'b0;
      end else begin
        pixel_x       <= nx;
        pixel_y       <= ny;
        step_diagonal <= diag;
        region_code   <= region;
        pixel_valid   <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step && !zero |-> (cnt != '0) && (cnt <= major_len))
    else $error("step counter outside the major-axis length");
`endif

endmodule

`default_nettype wire

@@ rtl/core/octant_bresenham_line_raster.sv @@
// ----------------------------------------------------------------------------
// octant_bresenham_line_raster
// Streaming line rasterizer: one segment in, one item per pixel out.
// ----------------------------------------------------------------------------
// A segment is taken while the block is idle; setup folds it into the first
// octant and labels the octant. A single step unit then walks the midpoint
// loop and places one pixel per cycle into the output register while the
// output slot is free, and the next segment is accepted right after the
// last item is registered. The start pixel is not emitted; the end pixel
// carries tlast.
`timescale 1ns / 1ps
`default_nettype none

module octant_bresenham_line_raster
  import obl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // pixel_x, pixel_y, step_diagonal, region_code
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // pixel_valid
  output logic                        m_tuser,
  output logic                        m_tlast
);

  obl_cmd_t cmd;
  obl_sts_t sts;
  coord_t   pixel_x, pixel_y;
  logic     step_diagonal;
  region_t  region_code;

  obl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  obl_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_tdata       (s_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .step_diagonal (step_diagonal),
    .region_code   (region_code),
    .pixel_valid   (m_tuser),
    .last_pixel    (m_tlast)
  );

  assign m_tdata = OUT_TDATA_W'({region_code, step_diagonal, pixel_y, pixel_x});

endmodule

`default_nettype wire

@@ bench/obl_line_checker.sv @@
// ----------------------------------------------------------------------------
// obl_line_checker
// Watches both streams of the line rasterizer, walks each accepted segment
// through its own midpoint loop and compares every pixel item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obl_line_checker
  import obl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  // pixel_x, pixel_y, step_diagonal, region_code
  input  wire logic [OUT_TDATA_W-1:0] m_tdata,
  // pixel_valid
  input  wire logic                   m_tuser,
  input  wire logic                   m_tlast,
  output int                          errors,
  output int                          outstanding
);

  typedef struct packed {
    coord_t  px;
    coord_t  py;
    logic    diag;
    region_t region;
    logic    valid;
    logic    last;
  } pixel_item_t;

  // octant label, indexed by {swap, mirror x, mirror y}
  localparam region_t OCTANT_LABEL [8] = '{4'd1, 4'd8, 4'd4, 4'd5,
                                           4'd2, 4'd3, 4'd7, 4'd6};

  pixel_item_t pixel_q[$];
  int          mismatches = 0;

  assign errors = mismatches;

  // append one expected item at the tail of the queue
  function automatic void add_expected(input pixel_item_t it);
    pixel_q.insert(pixel_q.size(), it);
  endfunction

  task automatic expand_segment(input coord_t x0, input coord_t y0,
                                input coord_t x1, input coord_t y1);
    int          sx, sy, dx, dy, adx, ady, major, minor, dec, off, px, py;
    logic        swap, fx, fy;
    pixel_item_t it;
    sx = x0;
    sy = y0;
    dx = int'(x1) - sx;
    dy = int'(y1) - sy;
    if (dx == 0 && dy == 0) begin
      it = '0;
      it.region = REGION_NONE;
      it.last = 1'b1;
      add_expected(it);
      return;
    end
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    swap = ady > adx;
    fx = (swap ? dy : dx) < 0;
    fy = (swap ? dx : dy) < 0;
    major = swap ? ady : adx;
    minor = swap ? adx : ady;
    dec = 2 * minor - major;
    off = 0;
    for (int k = 1; k <= major; k++) begin
      // a zero decision value takes the diagonal step
      if (dec < 0) begin
        dec += 2 * minor;
        it.diag = 1'b0;
      end else begin
        off++;
        dec += 2 * (minor - major);
        it.diag = 1'b1;
      end
      if (swap) begin
        py = sy + (fx ? -k : k);
        px = sx + (fy ? -off : off);
      end else begin
        px = sx + (fx ? -k : k);
        py = sy + (fy ? -off : off);
      end
      it.px = px[COORD_BITS-1:0];
      it.py = py[COORD_BITS-1:0];
      it.region = OCTANT_LABEL[{swap, fx, fy}];
      it.valid = 1'b1;
      it.last = (k == major);
      add_expected(it);
    end
  endtask

  always @(posedge clk) begin
    pixel_item_t got, want;
    if (rst) begin
      pixel_q.delete();
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.px = m_tdata[COORD_BITS-1:0];
        got.py = m_tdata[2*COORD_BITS-1:COORD_BITS];
        got.diag = m_tdata[2*COORD_BITS];
        got.region = m_tdata[2*COORD_BITS+4:2*COORD_BITS+1];
        got.valid = m_tuser;
        got.last = m_tlast;
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item x=%0d y=%0d diag=%0b region=%0d valid=%0b last=%0b",
                     $realtime, got.px, got.py, got.diag, got.region, got.valid, got.last);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: pixel mismatch", $realtime);
              $display("  exp x=%0d y=%0d diag=%0b region=%0d valid=%0b last=%0b",
                       want.px, want.py, want.diag, want.region, want.valid, want.last);
              $display("  got x=%0d y=%0d diag=%0b region=%0d valid=%0b last=%0b",
                       got.px, got.py, got.diag, got.region, got.valid, got.last);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        expand_segment(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS],
                       s_tdata[3*COORD_BITS-1:2*COORD_BITS],
                       s_tdata[4*COORD_BITS-1:3*COORD_BITS]);
      outstanding <= pixel_q.size();
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_octant_bresenham_line_raster.sv @@
// ----------------------------------------------------------------------------
// tb_octant_bresenham_line_raster
// Drives segments into the rasterizer with bursty input and a stalling
// output; the checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_octant_bresenham_line_raster;
  import obl_pkg::*;

  localparam int RANDOM_SEGMENTS = 420;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } segment_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_MOSTLY,
    RX_SPARSE,
    RX_STALLS
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  int                     errors;
  int                     outstanding;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       rx_stall = 0;
  int       burst_left = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  octant_bresenham_line_raster u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  obl_line_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // output side: each mode holds for a random stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_mode <= RX_FREE;
      rx_left <= 0;
      rx_stall <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 96);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_stall <= $urandom_range(1, 20);
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic coord_t clip(input int v);
    int c;
    c = v < -32 ? -32 : (v > 31 ? 31 : v);
    return coord_t'(c);
  endfunction

  function automatic segment_t random_segment();
    segment_t sg;
    int       pick;
    pick = $urandom_range(0, 9);
    sg.x0 = coord_t'($urandom);
    sg.y0 = coord_t'($urandom);
    sg.x1 = coord_t'($urandom);
    sg.y1 = coord_t'($urandom);
    if (pick >= 5 && pick < 8) begin
      // short segments around the start point
      sg.x1 = clip(int'(sg.x0) + $urandom_range(0, 10) - 5);
      sg.y1 = clip(int'(sg.y0) + $urandom_range(0, 10) - 5);
    end else if (pick == 8) begin
      case ($urandom_range(0, 2))
        0: sg.y1 = sg.y0;
        1: sg.x1 = sg.x0;
        default: sg.y1 = clip(int'(sg.y0) + (int'(sg.x1) - int'(sg.x0)));
      endcase
    end else if (pick == 9) begin
      sg.x1 = sg.x0;
      sg.y1 = sg.y0;
    end
    return sg;
  endfunction

  task automatic send_segment(input segment_t sg);
    s_tdata <= {sg.y1, sg.x1, sg.y0, sg.x0};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // bursts of random length separated by random gaps
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  segment_t directed[$] = '{
    '{6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{-6'sd32, -6'sd32, -6'sd32, -6'sd32},
    '{6'sd31, 6'sd31, 6'sd31, 6'sd31},
    '{-6'sd32, 6'sd0, 6'sd31, 6'sd0},
    '{6'sd31, 6'sd5, -6'sd32, 6'sd5},
    '{6'sd0, -6'sd32, 6'sd0, 6'sd31},
    '{6'sd7, 6'sd31, 6'sd7, -6'sd32},
    '{-6'sd32, -6'sd32, 6'sd31, 6'sd31},
    '{6'sd31, -6'sd32, -6'sd32, 6'sd31},
    '{6'sd0, 6'sd0, 6'sd2, 6'sd1},
    '{6'sd0, 6'sd0, 6'sd5, 6'sd2},
    '{6'sd0, 6'sd0, 6'sd5, -6'sd2},
    '{6'sd0, 6'sd0, -6'sd5, 6'sd2},
    '{6'sd0, 6'sd0, -6'sd5, -6'sd2},
    '{6'sd0, 6'sd0, 6'sd2, 6'sd5},
    '{6'sd0, 6'sd0, -6'sd2, 6'sd5},
    '{6'sd0, 6'sd0, 6'sd2, -6'sd5},
    '{6'sd0, 6'sd0, -6'sd2, -6'sd5},
    '{6'sd3, 6'sd3, 6'sd4, 6'sd3},
    '{-6'sd32, 6'sd31, 6'sd31, -6'sd32},
    '{-6'sd1, -6'sd1, 6'sd0, 6'sd0},
    '{6'sd10, -6'sd20, -6'sd21, 6'sd9}
  };

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed segments back to back
    foreach (directed[i]) send_segment(directed[i]);
    drain();

    for (int n = 0; n < RANDOM_SEGMENTS; n++) begin
      if (n == RANDOM_SEGMENTS / 3) drain();
      else if (n > 0) pace();
      send_segment(random_segment());
    end
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("** octant_bresenham_line_raster: PASSED **");
    end else begin
      if (outstanding != 0) $display("%0d pixel items never arrived", outstanding);
      $display("** octant_bresenham_line_raster: FAILED **");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d pixel items outstanding", outstanding);
    $display("** octant_bresenham_line_raster: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
